// File: hw/rtl/pcx_rle_pkg.sv
// Package with shared types and constants of the run-length line decoder.
`default_nettype none

package pcx_rle_pkg;

  localparam int BYTE_W       = 8;
  localparam int RUN_W        = 6;
  localparam int LINE_LEN_W   = 18;
  localparam int CFG_DATA_W   = 18;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;

  localparam logic [CFG_INDEX_W-1:0] CFG_COMPRESSED  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LINE_LENGTH = 1'b1;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;    // input transaction taken this cycle
    logic run_step;  // emit one more copy of the held byte
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic arm;   // accepted byte is a count byte, no output
    logic last;  // byte emitted this cycle closes the item
  } dp_status_t;

endpackage

`default_nettype wire

// File: hw/rtl/pcx_rle_if.sv
// Valid/ready channel interfaces for encoded input and decoded output.
`default_nettype none

interface pcx_rle_code_if;
  logic                              valid;
  logic                              ready;
  logic [pcx_rle_pkg::BYTE_W-1:0]    code_byte;

  modport source (output valid, output code_byte, input ready);
  modport sink   (input valid, input code_byte, output ready);
endinterface

interface pcx_rle_pixel_if;
  logic                              valid;
  logic                              ready;
  logic [pcx_rle_pkg::BYTE_W-1:0]    pixel_byte;
  logic                              line_end;
  logic                              run_last;

  modport source (output valid, output pixel_byte, output line_end, output run_last,
                  input ready);
  modport sink   (input valid, input pixel_byte, input line_end, input run_last,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pcx_rle_dp.sv
// Datapath: configuration registers, run state, line position and output register.
`default_nettype none

module pcx_rle_dp #(
  parameter int POSITION_BITS = 18
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  cfg_we,
  input  wire logic [pcx_rle_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [pcx_rle_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  wire logic [pcx_rle_pkg::BYTE_W-1:0]        in_code_byte,
  input  wire pcx_rle_pkg::dp_cmd_t                  cmd,
  output pcx_rle_pkg::dp_status_t                    status,
  output logic [pcx_rle_pkg::BYTE_W-1:0]             out_pixel_byte,
  output logic                                       out_line_end,
  output logic                                       out_run_last
);

  localparam int CMP_W = ((POSITION_BITS > pcx_rle_pkg::LINE_LEN_W) ?
                          POSITION_BITS : pcx_rle_pkg::LINE_LEN_W) + 1;

  logic                                  compressed_r;
  logic [pcx_rle_pkg::LINE_LEN_W-1:0]    line_length_r;
  logic                                  run_pending_r;
  logic [pcx_rle_pkg::RUN_W-1:0]         run_count_r;
  logic [POSITION_BITS-1:0]              pos_r;
  logic [pcx_rle_pkg::RUN_W-1:0]         remain_r;
  logic [pcx_rle_pkg::BYTE_W-1:0]        byte_r;
  logic [pcx_rle_pkg::BYTE_W-1:0]        pixel_r;
  logic                                  line_end_r;
  logic                                  run_last_r;

  logic [pcx_rle_pkg::BYTE_W-1:0]        cur_byte;
  logic [CMP_W-1:0]                      pos_ext;
  logic [CMP_W-1:0]                      len_ext;
  logic                                  ends;
  logic                                  is_count;
  logic [pcx_rle_pkg::RUN_W-1:0]         acc_copies;
  logic                                  acc_last;
  logic                                  step_last;
  logic                                  last;
  logic                                  emit;

  always_comb begin
    cur_byte   = cmd.run_step ? byte_r : in_code_byte;
    pos_ext    = CMP_W'(pos_r);
    len_ext    = CMP_W'(line_length_r);
    // Line length zero behaves as one; a position at its top value always ends the line
    ends       = ((pos_ext + CMP_W'(1)) >= len_ext) || (pos_r == '1);
    is_count   = compressed_r && !run_pending_r && (in_code_byte > pcx_rle_pkg::RUN_MARK);
    acc_copies = (compressed_r && run_pending_r) ? run_count_r
                                                 : pcx_rle_pkg::RUN_W'(1);
    acc_last   = ends || (acc_copies == pcx_rle_pkg::RUN_W'(1));
    step_last  = ends || (remain_r == pcx_rle_pkg::RUN_W'(1));
    last       = cmd.run_step ? step_last : acc_last;
    emit       = (cmd.accept && !is_count) || cmd.run_step;
    status.arm  = is_count;
    status.last = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      compressed_r  <= 1'b1;
      line_length_r <= pcx_rle_pkg::LINE_LEN_W'(1);
      run_pending_r <= 1'b0;
      run_count_r   <= pcx_rle_pkg::RUN_W'(1);
      pos_r         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          pcx_rle_pkg::CFG_COMPRESSED:  compressed_r  <= cfg_wdata[0];
          pcx_rle_pkg::CFG_LINE_LENGTH: line_length_r <= cfg_wdata[pcx_rle_pkg::LINE_LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (is_count) begin
          run_pending_r <= 1'b1;
          run_count_r   <= pcx_rle_pkg::RUN_W'(in_code_byte - pcx_rle_pkg::RUN_MARK);
        end else begin
          run_pending_r <= 1'b0;
        end
      end
      if (emit) begin
        pos_r <= ends ? '0 : (pos_r + POSITION_BITS'(1));
      end
    end
  end

  // Payload and run bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r   <= in_code_byte;
      remain_r <= acc_copies - pcx_rle_pkg::RUN_W'(1);
    end else if (cmd.run_step) begin
      remain_r <= remain_r - pcx_rle_pkg::RUN_W'(1);
    end
    if (emit) begin
      pixel_r    <= cur_byte;
      line_end_r <= ends;
      run_last_r <= last;
    end
  end

  assign out_pixel_byte = pixel_r;
  assign out_line_end   = line_end_r;
  assign out_run_last   = run_last_r;

endmodule

`default_nettype wire

// File: hw/rtl/pcx_rle_ctrl.sv
// Controller: accept/run state machine and output valid flag.
`default_nettype none

module pcx_rle_ctrl (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output pcx_rle_pkg::dp_cmd_t          cmd,
  input  wire pcx_rle_pkg::dp_status_t  status
);

  pcx_rle_pkg::state_t state_r, state_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_free;
  logic                emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pcx_rle_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_free     = !out_valid_r || out_ready;
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.run_step = 1'b0;
    state_nxt    = state_r;
    case (state_r)
      pcx_rle_pkg::S_IDLE: begin
        in_ready   = out_free;
        cmd.accept = in_valid && out_free;
        if (cmd.accept && !status.arm && !status.last) begin
          state_nxt = pcx_rle_pkg::S_RUN;
        end
      end
      pcx_rle_pkg::S_RUN: begin
        cmd.run_step = out_free;
        if (out_free && status.last) begin
          state_nxt = pcx_rle_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pcx_rle_pkg::S_IDLE;
      end
    endcase
    emit          = (cmd.accept && !status.arm) || cmd.run_step;
    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  // A run in progress always has a copy waiting in the output register
  a_run_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pcx_rle_pkg::S_RUN) |-> out_valid_r)
    else $error("run state without pending output");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !emit)
    else $error("output register overwritten while stalled");

  // A run step that closes the item returns the controller to idle
  a_run_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.run_step && status.last) |=> (state_r == pcx_rle_pkg::S_IDLE))
    else $error("run did not finish on its last copy");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/pcx_rle_line_decoder_unit.sv
// Top level of the run-length scanline decoder: controller plus datapath.
// Each result is registered in the output register and is visible in the cycle after its input transaction.
// Throughput: one literal byte or count byte per cycle while the output is free; the input is held
// while a run's remaining copies are emitted, one copy per cycle unless the output stalls.
// Copies past the end of the line are dropped, so a run ends early at a line boundary.
// Reset (rst_n low, synchronous): idle, no output, compressed mode, line length 1, position 0.
`default_nettype none

module pcx_rle_line_decoder_unit #(
  parameter int POSITION_BITS = 18
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  pcx_rle_code_if.sink                              in_chan,
  pcx_rle_pixel_if.source                           out_chan,
  input  wire logic                                 cfg_we,
  input  wire logic [pcx_rle_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [pcx_rle_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Command and status between the two halves
  pcx_rle_pkg::dp_cmd_t    cmd;
  pcx_rle_pkg::dp_status_t status;

  // Controller: decides when a transaction is taken and when a copy is emitted.
  // The input side stays open while the output register drains, so literal bytes
  // stream at one per cycle when the sink keeps ready high.
  pcx_rle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Datapath: holds configuration, the armed run count, the line position and
  // the output register. It flags count bytes and the last copy of an item.
  pcx_rle_dp #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_code_byte   (in_chan.code_byte),
    .cmd            (cmd),
    .status         (status),
    .out_pixel_byte (out_chan.pixel_byte),
    .out_line_end   (out_chan.line_end),
    .out_run_last   (out_chan.run_last)
  );

endmodule

`default_nettype wire
